/* rtl/cv3_pkg.sv */
// shared types, codes and constants for the int8 3x3 convolution point block
`timescale 1ns / 1ps

package cv3_pkg;

  localparam int IMG_HEIGHT       = 32;
  localparam int IMG_WIDTH        = 32;
  localparam int MAX_CHANNELS     = 16;
  localparam int MAX_OUT_CHANNELS = 16;

  localparam int KERNEL        = 3;
  localparam int TAPS          = KERNEL * KERNEL;
  localparam int REDUCE_STEPS  = 5;

  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 14;
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 5;
  localparam int OCH_W      = 4;
  localparam int WORD_W     = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int TAP_W      = 4;
  localparam int STEP_W     = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD_ACT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_WT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_PITCH   = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CHANNELS_RESET = 5'd16;
  localparam logic [CFG_DATA_W-1:0] PITCH_RESET    = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_REDUCE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              write_act;
    logic              write_wt;
    logic              tap_setup;
    logic              reduce_load;
    logic              reduce_sub;
    logic [STEP_W-1:0] shift;
    logic              issue;
    logic              finish;
    logic [TAP_W-1:0]  tap;
  } cmd_t;

  typedef struct packed {
    logic tap_inside;
    logic ci_zero;
    logic chan_last;
    logic pipe_busy;
    logic out_full;
  } status_t;

  // kernel row of a tap
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] tap);
    logic [1:0] r;
    case (tap) inside
      [4'd0:4'd2]: r = 2'd0;
      [4'd3:4'd5]: r = 2'd1;
      [4'd6:4'd8]: r = 2'd2;
      default:     r = 2'd0;
    endcase
    return r;
  endfunction

  // kernel column of a tap
  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] tap);
    logic [1:0] c;
    case (tap) inside
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/cv3_ctrl.sv */
// controller: sequences loads, taps, address reduction and the multiply-accumulate loop
`timescale 1ns / 1ps

module cv3_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cv3_pkg::MODE_W-1:0]  mode,
  input  cv3_pkg::status_t            status,
  output cv3_pkg::cmd_t               cmd
);

  cv3_pkg::state_t              state, state_next;
  logic [cv3_pkg::TAP_W-1:0]    tap, tap_next;
  logic [cv3_pkg::STEP_W-1:0]   rstep, rstep_next;

  localparam logic [cv3_pkg::TAP_W-1:0]  LAST_TAP  = cv3_pkg::TAP_W'(cv3_pkg::TAPS - 1);
  localparam logic [cv3_pkg::STEP_W-1:0] LAST_STEP = cv3_pkg::STEP_W'(cv3_pkg::REDUCE_STEPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cv3_pkg::ST_IDLE;
      tap   <= '0;
      rstep <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      rstep <= rstep_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    rstep_next = rstep;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.tap    = tap;
    case (state)
      cv3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode)
            cv3_pkg::MODE_LOAD_ACT: cmd.write_act = 1'b1;
            cv3_pkg::MODE_LOAD_WT:  cmd.write_wt  = 1'b1;
            cv3_pkg::MODE_COMPUTE: begin
              cmd.capture = 1'b1;
              tap_next    = '0;
              state_next  = cv3_pkg::ST_TAP;
            end
            default: ;
          endcase
        end
      end
      cv3_pkg::ST_TAP: begin
        if (status.tap_inside && !status.ci_zero) begin
          cmd.tap_setup = 1'b1;
          rstep_next    = '0;
          state_next    = cv3_pkg::ST_REDUCE;
        end else if (tap == LAST_TAP) begin
          state_next = cv3_pkg::ST_DRAIN;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      cv3_pkg::ST_REDUCE: begin
        // first step forms pixel * pitch, then conditional subtracts of depth << 4 .. 0
        if (rstep == '0) begin
          cmd.reduce_load = 1'b1;
        end else begin
          cmd.reduce_sub = 1'b1;
          cmd.shift      = LAST_STEP - rstep;
        end
        rstep_next = rstep + 1'b1;
        if (rstep == LAST_STEP) begin
          state_next = cv3_pkg::ST_MAC;
        end
      end
      cv3_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.chan_last) begin
          if (tap == LAST_TAP) begin
            state_next = cv3_pkg::ST_DRAIN;
          end else begin
            tap_next   = tap + 1'b1;
            state_next = cv3_pkg::ST_TAP;
          end
        end
      end
      cv3_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = cv3_pkg::ST_FINISH;
        end
      end
      cv3_pkg::ST_FINISH: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = cv3_pkg::ST_IDLE;
        end
      end
      default: state_next = cv3_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/cv3_datapath.sv */
// datapath: config registers, activation and weight stores, address units, mac pipeline
`timescale 1ns / 1ps

module cv3_datapath #(
  parameter int IMG_HEIGHT       = cv3_pkg::IMG_HEIGHT,
  parameter int IMG_WIDTH        = cv3_pkg::IMG_WIDTH,
  parameter int MAX_CHANNELS     = cv3_pkg::MAX_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cv3_pkg::MAX_OUT_CHANNELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cv3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [cv3_pkg::ADDR_W-1:0]         load_address,
  input  logic signed [cv3_pkg::BYTE_W-1:0]  load_value,
  input  logic [cv3_pkg::COORD_W-1:0]        row,
  input  logic [cv3_pkg::COORD_W-1:0]        column,
  input  logic [cv3_pkg::OCH_W-1:0]          out_channel,
  input  logic signed [cv3_pkg::WORD_W-1:0]  bias,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [cv3_pkg::WORD_W-1:0]  sum,
  input  cv3_pkg::cmd_t                      cmd,
  output cv3_pkg::status_t                   status
);

  localparam int ACT_DEPTH = IMG_HEIGHT * IMG_WIDTH * MAX_CHANNELS;
  localparam int WT_DEPTH  = MAX_OUT_CHANNELS * MAX_CHANNELS * cv3_pkg::TAPS;
  localparam int ACT_AW    = $clog2(ACT_DEPTH);
  localparam int WT_AW     = $clog2(WT_DEPTH);
  localparam int ACT_REM_W = ACT_AW + cv3_pkg::REDUCE_STEPS;
  localparam int WT_REM_W  = WT_AW + cv3_pkg::REDUCE_STEPS;
  localparam int PIX_W     = $clog2(IMG_HEIGHT * IMG_WIDTH);
  localparam int RC_W      = 10;
  localparam int WB_W      = WT_REM_W;
  localparam int CH_W      = cv3_pkg::CFG_DATA_W;
  localparam int PROD_W    = 2 * cv3_pkg::BYTE_W;

  logic signed [cv3_pkg::BYTE_W-1:0] act_mem [ACT_DEPTH];
  logic signed [cv3_pkg::BYTE_W-1:0] wt_mem  [WT_DEPTH];

  logic [cv3_pkg::CFG_DATA_W-1:0] channels_in_use;
  logic [cv3_pkg::CFG_DATA_W-1:0] channel_pitch;
  logic [CH_W-1:0]                ci;

  logic [cv3_pkg::COORD_W-1:0]        prow;
  logic [cv3_pkg::COORD_W-1:0]        pcol;
  logic [WB_W-1:0]                    wbase;
  logic signed [cv3_pkg::WORD_W-1:0]  bias_q;

  logic [PIX_W-1:0]     pix;
  logic [ACT_REM_W-1:0] act_rem;
  logic [WT_REM_W-1:0]  wt_rem;
  logic [CH_W-1:0]      chan;

  logic signed [cv3_pkg::BYTE_W-1:0] act_q;
  logic signed [cv3_pkg::BYTE_W-1:0] wt_q;
  logic signed [PROD_W-1:0]          prod;
  logic                              rd_v;
  logic                              mul_v;
  logic signed [cv3_pkg::WORD_W-1:0] acc;

  logic [RC_W-1:0]      rk;
  logic [RC_W-1:0]      ck;
  logic [ACT_REM_W-1:0] act_sub;
  logic [WT_REM_W-1:0]  wt_sub;
  logic [WT_REM_W-1:0]  wt_inc;

  // channel count saturated to the store's channel capacity
  always_comb begin
    if (7'(channels_in_use) > 7'(MAX_CHANNELS)) begin
      ci = CH_W'(MAX_CHANNELS);
    end else begin
      ci = channels_in_use;
    end
  end

  // pixel coordinates plus one, so the padding row and column sit at zero
  assign rk = RC_W'(prow) + RC_W'(cv3_pkg::tap_row(cmd.tap));
  assign ck = RC_W'(pcol) + RC_W'(cv3_pkg::tap_col(cmd.tap));

  assign status.tap_inside = (rk != '0) && (rk <= RC_W'(IMG_HEIGHT)) &&
                             (ck != '0) && (ck <= RC_W'(IMG_WIDTH));
  assign status.ci_zero    = (ci == '0);
  assign status.chan_last  = (chan == ci - 1'b1);
  assign status.pipe_busy  = rd_v | mul_v;
  assign status.out_full   = out_valid & ~out_ready;

  assign act_sub = ACT_REM_W'(ACT_DEPTH) << cmd.shift;
  assign wt_sub  = WT_REM_W'(WT_DEPTH) << cmd.shift;
  assign wt_inc  = wt_rem + WT_REM_W'(cv3_pkg::TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= cv3_pkg::CHANNELS_RESET;
      channel_pitch   <= cv3_pkg::PITCH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cv3_pkg::CFG_CHANNELS_IN_USE: channels_in_use <= cfg_data;
        cv3_pkg::CFG_CHANNEL_PITCH:   channel_pitch   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores: written by load transactions, read once per mac issue
  always_ff @(posedge clk) begin
    if (cmd.write_act && (32'(load_address) < 32'(ACT_DEPTH))) begin
      act_mem[ACT_AW'(load_address)] <= load_value;
    end
    if (cmd.write_wt && (32'(load_address) < 32'(WT_DEPTH))) begin
      wt_mem[WT_AW'(load_address)] <= load_value;
    end
    if (cmd.issue) begin
      act_q <= act_mem[act_rem[ACT_AW-1:0]];
      wt_q  <= wt_mem[wt_rem[WT_AW-1:0]];
    end
  end

  // point capture and address generation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prow   <= row;
      pcol   <= column;
      bias_q <= bias;
      wbase  <= (WB_W'(out_channel) * WB_W'(ci)) * WB_W'(cv3_pkg::TAPS);
    end
    if (cmd.tap_setup) begin
      pix    <= PIX_W'(rk - 1'b1) * PIX_W'(IMG_WIDTH) + PIX_W'(ck - 1'b1);
      wt_rem <= WT_REM_W'(wbase + WB_W'(cmd.tap));
    end
    if (cmd.reduce_load) begin
      act_rem <= ACT_REM_W'(pix) * ACT_REM_W'(channel_pitch);
    end
    if (cmd.reduce_sub) begin
      if (act_rem >= act_sub) begin
        act_rem <= act_rem - act_sub;
      end
      if (wt_rem >= wt_sub) begin
        wt_rem <= wt_rem - wt_sub;
      end
    end
    if (cmd.issue) begin
      act_rem <= (act_rem == ACT_REM_W'(ACT_DEPTH - 1)) ? '0 : act_rem + 1'b1;
      wt_rem  <= (wt_inc >= WT_REM_W'(WT_DEPTH)) ? wt_inc - WT_REM_W'(WT_DEPTH) : wt_inc;
    end
    if (rd_v) begin
      prod <= act_q * wt_q;
    end
  end

  // channel counter, pipeline valids, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      chan      <= '0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
      if (cmd.tap_setup) begin
        chan <= '0;
      end else if (cmd.issue) begin
        chan <= chan + 1'b1;
      end
      if (cmd.capture) begin
        acc <= '0;
      end else if (mul_v) begin
        acc <= acc + cv3_pkg::WORD_W'(prod);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sum <= acc + bias_q;
    end
  end

endmodule

/* rtl/int8_conv3x3_point.sv */
// top level of the int8 3x3 same-padding convolution point block
// load transaction: loads can follow each other every cycle while no compute transaction runs
// compute transaction: run time is set by the single mac unit, one channel per cycle
//   over ci channels for each inside tap, ci the saturated channel count, plus the
//   per-tap address reduction
// a new transaction is taken while an earlier result still waits in the output register
// reset clears control state and sets both config registers to 16; stores are not cleared
`timescale 1ns / 1ps

module int8_conv3x3_point #(
  parameter int IMG_HEIGHT       = cv3_pkg::IMG_HEIGHT,
  parameter int IMG_WIDTH        = cv3_pkg::IMG_WIDTH,
  parameter int MAX_CHANNELS     = cv3_pkg::MAX_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cv3_pkg::MAX_OUT_CHANNELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cv3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cv3_pkg::MODE_W-1:0]         mode,
  input  logic [cv3_pkg::ADDR_W-1:0]         load_address,
  input  logic signed [cv3_pkg::BYTE_W-1:0]  load_value,
  input  logic [cv3_pkg::COORD_W-1:0]        row,
  input  logic [cv3_pkg::COORD_W-1:0]        column,
  input  logic [cv3_pkg::OCH_W-1:0]          out_channel,
  input  logic signed [cv3_pkg::WORD_W-1:0]  bias,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cv3_pkg::WORD_W-1:0]  sum
);

  cv3_pkg::cmd_t    cmd;
  cv3_pkg::status_t status;

  cv3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  cv3_datapath #(
    .IMG_HEIGHT       (IMG_HEIGHT),
    .IMG_WIDTH        (IMG_WIDTH),
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .load_address (load_address),
    .load_value   (load_value),
    .row          (row),
    .column       (column),
    .out_channel  (out_channel),
    .bias         (bias),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sum          (sum),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
